/* hdl/page_fault_frame_replacement_defines.svh */
// Assertion macros shared by the modules of the replacement unit.
`ifndef PAGE_FAULT_FRAME_REPLACEMENT_DEFINES_SVH
`define PAGE_FAULT_FRAME_REPLACEMENT_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define PFR_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// A property that must hold at every clock edge outside reset.
`define PFR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

/* hdl/pfr_pkg.sv */
package pfr_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int NUM_FRAMES = 16;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_LFU  = 2'd2;
    localparam logic [1:0] POL_RAND = 2'd3;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_READ = 2'd1;
    localparam logic [1:0] ACC_RW   = 2'd3;

    localparam logic [1:0] ST_FILL    = 2'd0;
    localparam logic [1:0] ST_REPLACE = 2'd1;
    localparam logic [1:0] ST_UPGRADE = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;
    localparam logic [1:0] CFG_PAGES  = 2'd2;

    localparam int CFG_WIDTH = 11;

    typedef struct packed {
        logic [9:0]  fault_page;
        logic [15:0] random_value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] frame;
        logic [9:0] victim_page;
        logic       victim_dirty;
    } out_beat_t;

    // Control from the sequencer to the frame table.
    typedef struct packed {
        logic scan_start;
        logic scan_step;
        logic touch;
        logic fill;
        logic bump;
        logic clear;
    } ft_ctrl_t;

endpackage

/* hdl/pfr_ram.sv */
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pfr_frame_table.sv */
`include "page_fault_frame_replacement_defines.svh"

module pfr_frame_table #(
    parameter int NUM_FRAMES = 16,
    parameter int COUNT_BITS = 8,
    parameter int FB = $clog2(NUM_FRAMES),
    parameter int OB = $clog2(NUM_FRAMES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfr_pkg::ft_ctrl_t     ctrl,
    input  logic                  lfu,
    input  logic [OB-1:0]         occupied,
    input  logic [FB-1:0]         target,
    output logic [FB-1:0]         best,
    output logic [FB-1:0]         scan_idx
);
    import pfr_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [FB-1:0]         rank_reg  [NUM_FRAMES];
    logic [COUNT_BITS-1:0] count_reg [NUM_FRAMES];
    logic [FB-1:0]         best_reg;
    logic [FB-1:0]         idx_reg;
    logic                  better;
    logic [FB-1:0]         trank;

    assign best     = best_reg;
    assign scan_idx = idx_reg;
    assign trank    = rank_reg[target];

    // One compare per cycle over the scanned frame.
    always_comb
    begin
        if (lfu && count_reg[idx_reg] != count_reg[best_reg])
        begin
            better = count_reg[idx_reg] < count_reg[best_reg];
        end
        else
        begin
            better = rank_reg[idx_reg] > rank_reg[best_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
            idx_reg  <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                rank_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.scan_start)
            begin
                best_reg <= '0;
                idx_reg  <= FB'(1);
            end
            else if (ctrl.scan_step)
            begin
                if (better)
                begin
                    best_reg <= idx_reg;
                end
                idx_reg <= idx_reg + FB'(1);
            end
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                if (ctrl.touch && OB'(i) < occupied)
                begin
                    if (FB'(i) == target)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (rank_reg[i] < trank)
                    begin
                        rank_reg[i] <= rank_reg[i] + FB'(1);
                    end
                end
                if (ctrl.fill)
                begin
                    if (FB'(i) == target)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (OB'(i) < occupied)
                    begin
                        rank_reg[i] <= rank_reg[i] + FB'(1);
                    end
                end
            end
            if (ctrl.bump && count_reg[target] < COUNT_MAX)
            begin
                count_reg[target] <= count_reg[target] + COUNT_BITS'(1);
            end
            if (ctrl.clear)
            begin
                count_reg[target] <= '0;
            end
        end
    end

    `PFR_ASSERT_ALWAYS(a_one_op, clk, rst_n,
        $onehot0({ctrl.scan_start, ctrl.scan_step, ctrl.fill, ctrl.touch}),
        "frame table got overlapping commands")
    `PFR_ASSERT_IMPL(a_bump_touch, clk, rst_n, ctrl.bump, ctrl.touch,
        "use count bumped without a touch")
    `PFR_ASSERT_IMPL(a_best_scanned, clk, rst_n, ctrl.scan_step, best_reg < idx_reg,
        "scan best ahead of scan index")

endmodule

/* hdl/page_fault_frame_replacement.sv */
// Page fault frame replacement unit.
// The input channel in_valid/in_stall carries one fault beat: fault_page and
// random_value. The output channel out_valid/out_stall carries one result
// beat per fault: status, frame, victim page and its write-back flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for the
// policy, the frame count and the page count; write it only while idle.
// One fault is handled at a time. After the input beat is taken, a page out
// of range goes straight to the result; a resident page is touched, and a fill
// takes the next free frame, before the result. Otherwise a victim is chosen:
// one compare unit scans one frame per cycle, or, under the random policy, a
// bit-serial remainder of random_value by the frame count picks it; the
// victim's entry is then read and checked, and the new page is committed.
// A new fault is taken the cycle after the result beat leaves.
// While the receiver stalls, the result waits in its register and in_stall
// stays high. Reset empties all frames, sets policy FIFO and the counts to
// their maximums, and starts a pass that clears every page table RAM entry;
// in_stall stays high until that pass ends.
module page_fault_frame_replacement #(
    parameter int COUNT_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pfr_pkg::in_beat_t      in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pfr_pkg::out_beat_t     out_data,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [pfr_pkg::CFG_WIDTH-1:0] cfg_data
);
    import pfr_pkg::*;

    localparam int FB = $clog2(NUM_FRAMES);
    localparam int OB = $clog2(NUM_FRAMES + 1);
    localparam int PB = $clog2(NUM_PAGES);
    localparam int MW = FB + 2;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_LOOK   = 10'b0000000100,
        S_HIT    = 10'b0000001000,
        S_RMOD   = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_VREAD  = 10'b0001000000,
        S_VCHECK = 10'b0010000000,
        S_COMMIT = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t    state_reg, state_next;
    logic [1:0]  policy_reg;
    logic [4:0]  frames_reg;
    logic [10:0] pages_reg;
    logic [OB-1:0] occ_reg;
    logic [9:0]  page_reg;
    logic [15:0] rnd_reg;
    logic [OB-1:0] rem_reg;
    logic [3:0]  bit_cnt_reg;
    logic [PB-1:0] clr_reg;
    logic [FB-1:0] target_reg;
    logic [9:0]  vpage_reg;
    logic        vdirty_reg;
    logic [1:0]  status_reg;
    logic        out_valid_reg;

    logic [9:0] owner_reg [NUM_FRAMES];

    logic [OB-1:0] nfr;
    logic [11:0]   npg;
    ft_ctrl_t      ctrl;
    logic [FB-1:0] best, scan_idx;
    logic          map_we;
    logic [PB-1:0] map_waddr, map_raddr;
    logic [MW-1:0] map_wdata, map_rdata;
    logic [1:0]    acc_rd;
    logic [FB-1:0] frame_rd;
    logic [PB-1:0] page_idx, vpage_idx;
    logic [OB:0]   cand;
    logic [OB-1:0] rem_next;

    always_comb
    begin
        if (frames_reg == 5'd0)
        begin
            nfr = OB'(1);
        end
        else if (32'(frames_reg) > NUM_FRAMES)
        begin
            nfr = OB'(NUM_FRAMES);
        end
        else
        begin
            nfr = OB'(frames_reg);
        end
        if (32'(pages_reg) > NUM_PAGES)
        begin
            npg = 12'(NUM_PAGES);
        end
        else
        begin
            npg = 12'(pages_reg);
        end
    end

    assign page_idx  = PB'(page_reg);
    assign vpage_idx = PB'(owner_reg[target_reg]);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = '{status: status_reg, frame: 4'(target_reg),
                         victim_page: vpage_reg, victim_dirty: vdirty_reg};
    assign map_raddr = (state_reg == S_IDLE) ? PB'(in_data.fault_page) : vpage_idx;
    assign acc_rd    = map_rdata[MW-1:FB];
    assign frame_rd  = map_rdata[FB-1:0];
    assign cand      = {rem_reg, rnd_reg[15]};
    assign rem_next  = (cand >= {1'b0, nfr}) ? OB'(cand - {1'b0, nfr}) : OB'(cand);

    // Each page table entry holds the access state above the frame number.
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = page_idx;
        map_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_reg;
        end
        else if (state_reg == S_HIT)
        begin
            map_we    = 1'b1;
            map_wdata = {ACC_RW, target_reg};
        end
        else if (state_reg == S_VCHECK)
        begin
            map_we    = 1'b1;
            map_waddr = vpage_idx;
        end
        else if (state_reg == S_COMMIT)
        begin
            map_we    = 1'b1;
            map_wdata = {ACC_READ, target_reg};
        end
    end

    pfr_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    pfr_frame_table #(.NUM_FRAMES(NUM_FRAMES), .COUNT_BITS(COUNT_BITS)) u_ft (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .lfu      (policy_reg == POL_LFU),
        .occupied (occ_reg),
        .target   (target_reg),
        .best     (best),
        .scan_idx (scan_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == PB'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (12'(page_reg) >= npg)
                begin
                    state_next = S_OUT;
                end
                else if (acc_rd != ACC_NONE)
                begin
                    state_next = S_HIT;
                end
                else if (occ_reg < nfr)
                begin
                    state_next = S_COMMIT;
                end
                else if (policy_reg == POL_RAND)
                begin
                    state_next = S_RMOD;
                end
                else
                begin
                    ctrl.scan_start = 1'b1;
                    state_next      = S_SCAN;
                end
            end
            S_HIT:
            begin
                ctrl.touch = 1'b1;
                ctrl.bump  = (policy_reg == POL_LFU);
                state_next = S_OUT;
            end
            S_RMOD:
            begin
                if (bit_cnt_reg == 4'd15)
                begin
                    state_next = S_VREAD;
                end
            end
            S_SCAN:
            begin
                if (OB'(scan_idx) >= nfr || scan_idx == '0)
                begin
                    state_next = S_VREAD;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            S_VREAD:
            begin
                state_next = S_VCHECK;
            end
            S_VCHECK:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (status_reg == ST_FILL)
                begin
                    ctrl.fill = 1'b1;
                end
                else
                begin
                    ctrl.touch = 1'b1;
                end
                ctrl.clear = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            policy_reg    <= POL_FIFO;
            frames_reg    <= 5'd16;
            pages_reg     <= 11'd1024;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + PB'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POLICY: policy_reg <= cfg_data[1:0];
                    CFG_FRAMES: frames_reg <= cfg_data[4:0];
                    CFG_PAGES:  pages_reg  <= cfg_data[10:0];
                    default:    ;
                endcase
            end
            if (state_reg == S_LOOK && state_next == S_COMMIT)
            begin
                target_reg <= FB'(occ_reg);
                status_reg <= ST_FILL;
            end
            if (state_reg == S_LOOK && state_next == S_OUT)
            begin
                status_reg <= ST_RANGE;
                target_reg <= '0;
                vpage_reg  <= '0;
                vdirty_reg <= 1'b0;
            end
            if (state_reg == S_LOOK && state_next == S_HIT)
            begin
                status_reg <= ST_UPGRADE;
                target_reg <= frame_rd;
                vpage_reg  <= '0;
                vdirty_reg <= 1'b0;
            end
            if (state_reg == S_RMOD && state_next == S_VREAD)
            begin
                target_reg <= FB'(rem_next);
                status_reg <= ST_REPLACE;
            end
            if (state_reg == S_SCAN && state_next == S_VREAD)
            begin
                target_reg <= best;
                status_reg <= ST_REPLACE;
            end
            if (state_reg == S_VREAD)
            begin
                vpage_reg <= 10'(vpage_idx);
            end
            if (state_reg == S_VCHECK)
            begin
                vdirty_reg <= (acc_rd == ACC_RW);
            end
            if (state_reg == S_COMMIT)
            begin
                owner_reg[target_reg] <= page_reg;
                if (status_reg == ST_FILL)
                begin
                    occ_reg    <= occ_reg + OB'(1);
                    vpage_reg  <= '0;
                    vdirty_reg <= 1'b0;
                end
            end
            if (state_next == S_OUT && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == S_OUT && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            page_reg    <= in_data.fault_page;
            rnd_reg     <= in_data.random_value;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (state_reg == S_RMOD)
        begin
            rnd_reg     <= {rnd_reg[14:0], 1'b0};
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + 4'd1;
        end
    end

    `PFR_ASSERT_IMPL(a_out_state, clk, rst_n, out_valid, state_reg == S_OUT,
        "result shown outside the output state")
    `PFR_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, 32'(occ_reg) <= NUM_FRAMES,
        "occupied frame count above frame total")
    `PFR_ASSERT_IMPL(a_fill_free, clk, rst_n,
        state_reg == S_COMMIT && status_reg == ST_FILL, occ_reg < nfr,
        "fill into a full frame set")

endmodule
